### design/hlsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hlsc_pkg: shared definitions for the HDR luma soft clamp
// Field widths, luma weights, register indexes and reset values, and the
// signed clipping of a quotient magnitude used at both divider outputs.
// ----------------------------------------------------------------------------
package hlsc_pkg;

  localparam int CHAN_W     = 32;                 // one Q19.12 color channel
  localparam int NUM_CH     = 3;
  localparam int PAR_W      = 31;                 // threshold and compression point
  localparam int CFG_DATA_W = 32;
  localparam int HLSC_CFG_IDX_W = 8;

  localparam int WT_W       = 16;                 // Q0.16 luma weights
  localparam int LUMA_SHIFT = 16;
  localparam int PROD_W     = CHAN_W + WT_W + 1;  // channel times weight, signed
  localparam int SQ_W       = 2 * PAR_W;          // L*L and C*luma
  localparam int DEN_W      = PAR_W + 3;          // 2L - C - luma, signed
  localparam int DVD_W      = 2 * CHAN_W;         // dividend magnitude
  localparam int QUO_W      = CHAN_W;             // quotient bits kept

  localparam logic [WT_W-1:0]   LUMA_WT [NUM_CH] = '{16'd13933, 16'd46871, 16'd4732};
  localparam logic [PROD_W-1:0] LUMA_RND = PROD_W'(32768);

  localparam int REG_LIN_THR = 0;
  localparam int REG_CMP_PT  = 1;
  localparam logic [PAR_W-1:0] LIN_THR_RST = 31'd16777216;
  localparam logic [PAR_W-1:0] CMP_PT_RST  = 31'd67108864;

  localparam logic [CHAN_W-1:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [CHAN_W-1:0] S32_MIN = 32'h8000_0000;

  typedef logic [NUM_CH-1:0][CHAN_W-1:0] chans_t;

  typedef struct packed {
    logic               sat;
    logic [CHAN_W-1:0]  val;
  } clip_t;

  // Payload that travels beside the num/den divider.
  typedef struct packed {
    logic               comp;
    logic               neg;
    logic               dz;
    logic               npos;
    logic               nneg;
    logic [CHAN_W-1:0]  luma;
    chans_t             ch;
  } qside_t;

  // Payload that travels beside the three channel dividers.
  typedef struct packed {
    logic               comp;
    logic               satq;
    logic [NUM_CH-1:0]  pneg;
    chans_t             ch;
  } cside_t;

  // Applies the sign to an unsigned quotient and clips it to 32-bit signed.
  // ovf means the true quotient magnitude is 2^32 or more.
  function automatic clip_t clip_quo(input logic neg, input logic ovf,
                                     input logic [QUO_W-1:0] mag);
    clip_t r;
    r.sat = 1'b0;
    r.val = mag;
    if (!neg) begin
      if (ovf || mag[QUO_W-1]) begin
        r.sat = 1'b1;
        r.val = S32_MAX;
      end
    end else begin
      if (ovf || (mag > S32_MIN)) begin
        r.sat = 1'b1;
        r.val = S32_MIN;
      end else begin
        r.val = -mag;
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### design/hlsc_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hlsc_divider: pipelined unsigned restoring divider
// One quotient bit per register stage, QUO_W stages. The dividend high half
// is compared against the divisor up front; when it is not smaller, the
// quotient would need more than QUO_W bits and ovf is raised instead.
// ----------------------------------------------------------------------------
module hlsc_divider
  import hlsc_pkg::*;
#(
  parameter int DVS_W = PAR_W
) (
  input  logic              clk,
  input  logic              en,
  input  logic [DVD_W-1:0]  dvd,
  input  logic [DVS_W-1:0]  dvs,
  output logic [QUO_W-1:0]  quo,
  output logic              ovf
);

  localparam int RW   = DVS_W + 1;
  localparam int HI_W = DVD_W - QUO_W;
  localparam int CW   = (DVS_W > HI_W) ? DVS_W : HI_W;

  logic [RW-1:0]    rem_r   [QUO_W-1];
  logic [RW-1:0]    rem_nxt [QUO_W-1];
  logic [QUO_W-1:0] lo_r    [QUO_W-1];
  logic [QUO_W-1:0] lo_nxt  [QUO_W-1];
  logic [QUO_W-1:0] quo_r   [QUO_W];
  logic [QUO_W-1:0] quo_nxt [QUO_W];
  logic [DVS_W-1:0] dvs_r   [QUO_W-1];
  logic             ovf_r   [QUO_W];
  logic             ovf_in;

  assign ovf_in = CW'(dvd[DVD_W-1:QUO_W]) >= CW'(dvs);

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    logic [RW-1:0]    rem_prev;
    logic [QUO_W-1:0] lo_prev;
    logic [QUO_W-1:0] quo_prev;
    logic [DVS_W-1:0] dvs_prev;
    logic [RW-1:0]    shifted;
    logic [RW:0]      diff;

    if (k == 0) begin : g_first
      assign rem_prev = RW'(dvd[DVD_W-1:QUO_W]);
      assign lo_prev  = dvd[QUO_W-1:0];
      assign quo_prev = '0;
      assign dvs_prev = dvs;
    end else begin : g_next
      assign rem_prev = rem_r[k-1];
      assign lo_prev  = lo_r[k-1];
      assign quo_prev = quo_r[k-1];
      assign dvs_prev = dvs_r[k-1];
    end

    // The partial remainder stays below the divisor, so its top bit is free.
    assign shifted    = {rem_prev[RW-2:0], lo_prev[QUO_W-1]};
    assign diff       = {1'b0, shifted} - {2'b00, dvs_prev};
    assign quo_nxt[k] = {quo_prev[QUO_W-2:0], ~diff[RW]};

    if (k < QUO_W - 1) begin : g_keep
      assign rem_nxt[k] = diff[RW] ? shifted : diff[RW-1:0];
      assign lo_nxt[k]  = {lo_prev[QUO_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r    <= rem_nxt;
      lo_r     <= lo_nxt;
      quo_r    <= quo_nxt;
      dvs_r[0] <= dvs;
      ovf_r[0] <= ovf_in;
      for (int k = 1; k < QUO_W; k++) begin
        ovf_r[k] <= ovf_r[k-1];
      end
      for (int k = 1; k < QUO_W - 1; k++) begin
        dvs_r[k] <= dvs_r[k-1];
      end
    end
  end

  assign quo = quo_r[QUO_W-1];
  assign ovf = ovf_r[QUO_W-1];

endmodule
`default_nettype wire

### design/hdr_luma_soft_clamp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hdr_luma_soft_clamp: soft highlight compression of HDR RGB pixels
// Forms a Rec. 709 luma from a Q19.12 pixel; pixels above the linear
// threshold have all channels scaled by the same soft curve factor.
// ----------------------------------------------------------------------------
//  Channel  Direction  Transaction                        Payload
//  in_      sink       one pixel                          tdata: red, green, blue
//  out_     source     one pixel                          tdata: red, green, blue
//                                                         tuser: was_compressed, saturated
//  cfg_     sink       one register write                 index, data
//
// One pixel per clock in and out. The pipeline depth is set mostly by the
// 32-stage restoring dividers (curve factor, then one per channel for the
// division by luma). A synchronous reset clears all valid bits and reloads the
// threshold and compression point. While a result waits at the output and
// out_tready is low, the whole pipeline holds and in_tready drops.
// ----------------------------------------------------------------------------
module hdr_luma_soft_clamp
  import hlsc_pkg::*;
#(
  parameter int CFG_IDX_W = HLSC_CFG_IDX_W
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [NUM_CH*CHAN_W-1:0]   in_tdata,   // red_in, green_in, blue_in
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [NUM_CH*CHAN_W-1:0]   out_tdata,  // red_out, green_out, blue_out
  output logic [1:0]                 out_tuser,  // was_compressed, saturated
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data
);

  logic en;

  logic [PAR_W-1:0] lin_thr_r;
  logic [PAR_W-1:0] cmp_pt_r;

  // valid bits
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r, v9_r;
  logic vq_r [QUO_W];
  logic vc_r [QUO_W];
  logic out_valid_r;

  // stage payloads
  chans_t            ch1_r, ch2_r, ch3_r, ch4_r, ch5_r, ch7_r, ch8_r;
  logic [PROD_W-1:0] prod2_r  [NUM_CH];
  logic [PROD_W-1:0] prod_nxt [NUM_CH];
  logic [PROD_W-1:0] sum_nxt;
  logic [CHAN_W-1:0] luma3_r, luma4_r, luma5_r, luma7_r, luma8_r, luma9_r;
  logic              comp4_r, comp5_r, comp7_r, comp8_r;
  logic              comp_nxt;
  logic [SQ_W-1:0]   ll4_r, cl4_r;
  logic [DEN_W-1:0]  den4_r, den5_r, den_nxt;
  logic [DVD_W-1:0]  num5_r, num_nxt;
  logic [DVD_W-1:0]  nmag6_r;
  logic [DEN_W-1:0]  dmag6_r;
  qside_t            qs6_r, qs_nxt;
  qside_t            qs_r [QUO_W];
  logic [QUO_W-1:0]  q_quo;
  logic              q_ovf;
  clip_t             q_nxt;
  logic [CHAN_W-1:0] q7_r;
  logic              satq7_r, satq8_r;
  logic [DVD_W-1:0]  prod8_r  [NUM_CH];
  logic [DVD_W-1:0]  pmul_nxt [NUM_CH];
  logic [DVD_W-1:0]  pm9_r    [NUM_CH];
  cside_t            cs9_r, cs9_nxt;
  cside_t            cs_r [QUO_W];
  logic [QUO_W-1:0]  c_quo [NUM_CH];
  logic              c_ovf [NUM_CH];
  chans_t            res_nxt;
  logic [NUM_CH-1:0] csat_nxt;
  chans_t            out_data_r;
  logic [1:0]        out_user_r;

  // The pipeline moves as one; it only holds when the output is full and stalled.
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lin_thr_r <= LIN_THR_RST;
      cmp_pt_r  <= CMP_PT_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_IDX_W'(REG_LIN_THR)) begin
        lin_thr_r <= cfg_data[PAR_W-1:0];
      end else if (cfg_index == CFG_IDX_W'(REG_CMP_PT)) begin
        cmp_pt_r <= cfg_data[PAR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      v7_r        <= 1'b0;
      v8_r        <= 1'b0;
      v9_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < QUO_W; k++) begin
        vq_r[k] <= 1'b0;
        vc_r[k] <= 1'b0;
      end
    end else if (en) begin
      v1_r    <= in_tvalid;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      v4_r    <= v3_r;
      v5_r    <= v4_r;
      v6_r    <= v5_r;
      vq_r[0] <= v6_r;
      for (int k = 1; k < QUO_W; k++) begin
        vq_r[k] <= vq_r[k-1];
        vc_r[k] <= vc_r[k-1];
      end
      v7_r        <= vq_r[QUO_W-1];
      v8_r        <= v7_r;
      v9_r        <= v8_r;
      vc_r[0]     <= v9_r;
      out_valid_r <= vc_r[QUO_W-1];
    end
  end

  // Luma weights, then the rounded sum scaled back by 2^16 (arithmetic shift = floor).
  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      prod_nxt[k] = $signed(ch1_r[k]) * $signed({1'b0, LUMA_WT[k]});
    end
    sum_nxt = prod2_r[0] + prod2_r[1] + prod2_r[2] + LUMA_RND;
  end

  // Curve terms: num = L*L - C*luma, den = 2L - C - luma.
  always_comb begin
    comp_nxt = $signed(luma3_r) > $signed({1'b0, lin_thr_r});
    den_nxt  = {2'b00, lin_thr_r, 1'b0} - {3'b000, cmp_pt_r}
             - {{(DEN_W-CHAN_W){luma3_r[CHAN_W-1]}}, luma3_r};
    num_nxt  = {2'b00, ll4_r} - {2'b00, cl4_r};
  end

  always_comb begin
    qs_nxt.comp = comp5_r;
    qs_nxt.neg  = num5_r[DVD_W-1] ^ den5_r[DEN_W-1];
    qs_nxt.dz   = den5_r == '0;
    qs_nxt.npos = !num5_r[DVD_W-1] && (num5_r != '0);
    qs_nxt.nneg = num5_r[DVD_W-1];
    qs_nxt.luma = luma5_r;
    qs_nxt.ch   = ch5_r;
  end

  hlsc_divider #(
    .DVS_W (DEN_W)
  ) u_div_q (
    .clk (clk),
    .en  (en),
    .dvd (nmag6_r),
    .dvs (dmag6_r),
    .quo (q_quo),
    .ovf (q_ovf)
  );

  // Curve factor; a zero divisor saturates toward the sign of the numerator.
  always_comb begin
    q_nxt = clip_quo(qs_r[QUO_W-1].neg, q_ovf, q_quo);
    if (qs_r[QUO_W-1].dz) begin
      q_nxt.sat = 1'b1;
      if (qs_r[QUO_W-1].npos) begin
        q_nxt.val = S32_MAX;
      end else if (qs_r[QUO_W-1].nneg) begin
        q_nxt.val = S32_MIN;
      end else begin
        q_nxt.val = '0;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      pmul_nxt[k]     = $signed(ch7_r[k]) * $signed(q7_r);
      cs9_nxt.pneg[k] = prod8_r[k][DVD_W-1];
    end
    cs9_nxt.comp = comp8_r;
    cs9_nxt.satq = satq8_r;
    cs9_nxt.ch   = ch8_r;
  end

  for (genvar k = 0; k < NUM_CH; k++) begin : g_ch_div
    hlsc_divider #(
      .DVS_W (PAR_W)
    ) u_div_ch (
      .clk (clk),
      .en  (en),
      .dvd (pm9_r[k]),
      .dvs (luma9_r[PAR_W-1:0]),
      .quo (c_quo[k]),
      .ovf (c_ovf[k])
    );
  end

  // Luma is positive whenever the curve applies, so the product sign is the result sign.
  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      {csat_nxt[k], res_nxt[k]} = clip_quo(cs_r[QUO_W-1].pneg[k], c_ovf[k], c_quo[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ch1_r <= in_tdata;

      prod2_r <= prod_nxt;
      ch2_r   <= ch1_r;

      luma3_r <= sum_nxt[LUMA_SHIFT+CHAN_W-1:LUMA_SHIFT];
      ch3_r   <= ch2_r;

      comp4_r <= comp_nxt;
      ll4_r   <= lin_thr_r * lin_thr_r;
      cl4_r   <= cmp_pt_r * luma3_r[PAR_W-1:0];
      den4_r  <= den_nxt;
      luma4_r <= luma3_r;
      ch4_r   <= ch3_r;

      num5_r  <= num_nxt;
      den5_r  <= den4_r;
      comp5_r <= comp4_r;
      luma5_r <= luma4_r;
      ch5_r   <= ch4_r;

      nmag6_r <= num5_r[DVD_W-1] ? -num5_r : num5_r;
      dmag6_r <= den5_r[DEN_W-1] ? -den5_r : den5_r;
      qs6_r   <= qs_nxt;

      qs_r[0] <= qs6_r;
      for (int k = 1; k < QUO_W; k++) begin
        qs_r[k] <= qs_r[k-1];
        cs_r[k] <= cs_r[k-1];
      end

      q7_r    <= q_nxt.val;
      satq7_r <= q_nxt.sat;
      comp7_r <= qs_r[QUO_W-1].comp;
      luma7_r <= qs_r[QUO_W-1].luma;
      ch7_r   <= qs_r[QUO_W-1].ch;

      prod8_r <= pmul_nxt;
      satq8_r <= satq7_r;
      comp8_r <= comp7_r;
      luma8_r <= luma7_r;
      ch8_r   <= ch7_r;

      for (int k = 0; k < NUM_CH; k++) begin
        pm9_r[k] <= prod8_r[k][DVD_W-1] ? -prod8_r[k] : prod8_r[k];
      end
      luma9_r <= luma8_r;
      cs9_r   <= cs9_nxt;

      cs_r[0] <= cs9_r;

      out_data_r    <= cs_r[QUO_W-1].comp ? res_nxt : cs_r[QUO_W-1].ch;
      out_user_r[0] <= cs_r[QUO_W-1].comp;
      out_user_r[1] <= cs_r[QUO_W-1].comp && (cs_r[QUO_W-1].satq || (|csat_nxt));
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
`default_nettype wire

### design/hlsc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hlsc_checker: port-level checks for the HDR luma soft clamp
// Watches the stream ports for flow control and flag consistency.
// ----------------------------------------------------------------------------
module hlsc_checker
  import hlsc_pkg::*;
(
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     in_tready,
  input wire logic                     out_tvalid,
  input wire logic                     out_tready,
  input wire logic [NUM_CH*CHAN_W-1:0] out_tdata,
  input wire logic [1:0]               out_tuser
);

  // A stalled result must not change.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled output transaction changed");

  // Saturation only happens on the compressed path.
  a_sat_needs_comp: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tuser[0])
    else $error("saturated set on a pass-through pixel");

  // The input side takes a pixel whenever the output register can move.
  a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("in_tready does not follow the output stall");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind hdr_luma_soft_clamp hlsc_checker u_hlsc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire

### test/hlsc_pixel_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlsc_pixel_checker: result checker for the HDR luma soft clamp
// Watches the pixel, result and register channels of the block. For every
// accepted pixel it computes the expected compressed pixel and flags from its
// own copy of the threshold and compression point, and compares each accepted
// result field by field with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module hlsc_pixel_checker
  import hlsc_pkg::*;
#(
  parameter int IDX_W = HLSC_CFG_IDX_W
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  input  logic                     in_tready,
  input  logic [NUM_CH*CHAN_W-1:0] in_tdata,   // red_in, green_in, blue_in
  input  logic                     out_tvalid,
  input  logic                     out_tready,
  input  logic [NUM_CH*CHAN_W-1:0] out_tdata,  // red_out, green_out, blue_out
  input  logic [1:0]               out_tuser,  // was_compressed, saturated
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  output int                       fail_count,
  output int                       pending
);

  typedef struct packed {
    chans_t ch;
    logic   compressed;
    logic   clipped;
  } pixel_res_t;

  typedef struct packed {
    logic              clipped;
    logic [CHAN_W-1:0] val;
  } fit_t;

  // Rec. 709 weights in Q0.16; they sum to exactly one.
  localparam longint WT_RED   = 13933;
  localparam longint WT_GREEN = 46871;
  localparam longint WT_BLUE  = 4732;
  localparam longint S32_HI   = 64'sh7FFF_FFFF;
  localparam longint S32_LO   = -64'sh8000_0000;

  logic [PAR_W-1:0] thr;
  logic [PAR_W-1:0] knee;
  pixel_res_t       expected_pixels [$];
  int               mismatches;
  int               results_seen;
  string            ch_name [NUM_CH];

  assign fail_count = mismatches;

  initial begin
    mismatches   = 0;
    results_seen = 0;
    ch_name      = '{"red", "green", "blue"};
  end

  function automatic fit_t fit_s32(longint v);
    fit_t f;
    f.clipped = 1'b0;
    f.val     = CHAN_W'(v);
    if (v > S32_HI) begin
      f.clipped = 1'b1;
      f.val     = CHAN_W'(S32_HI);
    end else if (v < S32_LO) begin
      f.clipped = 1'b1;
      f.val     = CHAN_W'(S32_LO);
    end
    return f;
  endfunction

  function automatic pixel_res_t soft_clamp_pixel(chans_t px);
    pixel_res_t r;
    longint     ch [NUM_CH];
    longint     l, c, luma, num, den, q;
    fit_t       f;
    l = longint'(thr);
    c = longint'(knee);
    for (int k = 0; k < NUM_CH; k++) ch[k] = longint'($signed(px[k]));
    // Arithmetic shift of a signed value floors, as the rounding needs.
    luma = (WT_RED * ch[0] + WT_GREEN * ch[1] + WT_BLUE * ch[2] + 64'sd32768) >>> 16;
    r.ch         = px;
    r.compressed = 1'b0;
    r.clipped    = 1'b0;
    if (luma > l) begin
      r.compressed = 1'b1;
      num = l * l - c * luma;
      den = 2 * l - c - luma;
      if (den == 0) begin
        // The curve has a pole here, so the factor goes to the rail on the
        // side of the numerator's sign.
        r.clipped = 1'b1;
        q = (num > 0) ? S32_HI : ((num < 0) ? S32_LO : 64'sd0);
      end else begin
        f = fit_s32(num / den);
        r.clipped |= f.clipped;
        q = longint'($signed(f.val));
      end
      for (int k = 0; k < NUM_CH; k++) begin
        f = fit_s32((ch[k] * q) / luma);
        r.ch[k] = f.val;
        r.clipped |= f.clipped;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t ns: result %0d: %s is %0h, expected %0h",
             $time, results_seen, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : monitor
    pixel_res_t want;
    pixel_res_t got;
    if (!rst_n) begin
      thr  = LIN_THR_RST;
      knee = CMP_PT_RST;
      expected_pixels.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == IDX_W'(REG_LIN_THR)) begin
          thr = cfg_data[PAR_W-1:0];
        end else if (cfg_index == IDX_W'(REG_CMP_PT)) begin
          knee = cfg_data[PAR_W-1:0];
        end
      end
      if (in_tvalid && in_tready) begin
        expected_pixels.push_back(soft_clamp_pixel(in_tdata));
      end
      if (out_tvalid && out_tready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("transaction with no pixel outstanding, tdata[31:0]",
                          out_tdata[CHAN_W-1:0], 0);
        end else begin
          want           = expected_pixels.pop_front();
          got.ch         = out_tdata;
          got.compressed = out_tuser[0];
          got.clipped    = out_tuser[1];
          for (int k = 0; k < NUM_CH; k++) begin
            if (got.ch[k] !== want.ch[k]) begin
              report_mismatch(ch_name[k], got.ch[k], want.ch[k]);
            end
          end
          if (got.compressed !== want.compressed) begin
            report_mismatch("was_compressed", got.compressed, want.compressed);
          end
          if (got.clipped !== want.clipped) begin
            report_mismatch("saturated", got.clipped, want.clipped);
          end
        end
        results_seen++;
      end
    end
    pending <= expected_pixels.size();
  end

endmodule

### test/hdr_luma_soft_clamp_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdr_luma_soft_clamp_tb: stream test of the HDR luma soft clamp
// Drives directed pixels (channel extremes, the threshold edge, the pole of
// the curve) and then random pixels under a series of threshold and
// compression point settings, with random gaps on both stream sides. A
// separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module hdr_luma_soft_clamp_tb;
  import hlsc_pkg::*;

  localparam longint S32_HI = 64'sh7FFF_FFFF;

  logic                      clk;
  logic                      rst_n;
  logic                      in_tvalid;
  logic                      in_tready;
  logic [NUM_CH*CHAN_W-1:0]  in_tdata;
  logic                      out_tvalid;
  logic                      out_tready;
  logic [NUM_CH*CHAN_W-1:0]  out_tdata;
  logic [1:0]                out_tuser;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [HLSC_CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]     cfg_data;
  int                        fail_count;
  int                        pending;

  // Current register settings, used only to aim the random pixels.
  logic [PAR_W-1:0] cur_thr;
  logic [PAR_W-1:0] cur_knee;
  // When set, neither stream side inserts gaps.
  bit               calm;

  hdr_luma_soft_clamp i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  hlsc_pixel_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic chans_t rgb(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                                 logic [CHAN_W-1:0] b);
    return {b, g, r};
  endfunction

  function automatic chans_t random_pixel();
    chans_t px;
    longint l, span, v;
    int     mode;
    l    = longint'(cur_thr);
    span = 4 * l + 64'sd4096;
    if (span > S32_HI) span = S32_HI;
    for (int k = 0; k < NUM_CH; k++) px[k] = $urandom;
    mode = $urandom_range(0, 9);
    case (mode)
      2, 3: begin
        // Gray right around the threshold.
        v  = l + longint'($urandom_range(0, 4)) - 2;
        px = {NUM_CH{CHAN_W'(v)}};
      end
      4: begin
        // Gray at the pole of the curve, where the divisor is zero.
        v = 2 * l - longint'(cur_knee);
        if (v > l && v <= S32_HI) px = {NUM_CH{CHAN_W'(v)}};
      end
      5, 6, 7: begin
        for (int k = 0; k < NUM_CH; k++) px[k] = $urandom_range(0, 32'(span));
      end
      8: begin
        for (int k = 0; k < NUM_CH; k++) begin
          v     = longint'($urandom_range(0, 32'(span)));
          px[k] = CHAN_W'($urandom_range(0, 1) ? -v : v);
        end
      end
      9: begin
        for (int k = 0; k < NUM_CH; k++) px[k] = $urandom_range(0, 8192) - 4096;
      end
      default: ;
    endcase
    return px;
  endfunction

  // Leaves cfg_valid high; the caller lowers it after the last write.
  task automatic write_reg(int idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= HLSC_CFG_IDX_W'(idx);
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_LIN_THR) begin
      cur_thr = data[PAR_W-1:0];
    end else if (idx == REG_CMP_PT) begin
      cur_knee = data[PAR_W-1:0];
    end
  endtask

  task automatic configure(logic [CFG_DATA_W-1:0] thr_word,
                           logic [CFG_DATA_W-1:0] knee_word);
    write_reg(REG_LIN_THR, thr_word);
    write_reg(REG_CMP_PT, knee_word);
    // A write to an unused index must leave both registers alone.
    if ($urandom_range(0, 1)) write_reg(REG_CMP_PT + 1 + $urandom_range(0, 253), $urandom);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_pixel(chans_t px);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : result_sink
    int stall;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] thr_word, knee_word;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    calm      = 1'b0;
    cur_thr   = LIN_THR_RST;
    cur_knee  = CMP_PT_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: channel extremes and the threshold edge.
    push_pixel(rgb(32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
    push_pixel(rgb(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    push_pixel(rgb(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    push_pixel(rgb(32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000));
    push_pixel(rgb(32'h0000_0000, 32'h8000_0000, 32'h0000_0000));
    push_pixel(rgb(32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF));
    push_pixel(rgb(32'h0100_0000, 32'h0100_0000, 32'h0100_0000));
    push_pixel(rgb(32'h0100_0001, 32'h0100_0001, 32'h0100_0001));
    push_pixel(rgb(32'h0200_0000, 32'h0100_0000, 32'h0040_0000));
    push_pixel(rgb(32'hFFF0_0000, 32'h0300_0000, 32'h0300_0000));
    push_pixel(rgb(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    push_pixel(rgb(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555));
    push_pixel(rgb(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA));
    push_pixel(rgb(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
    push_pixel(rgb(32'h1000_0000, 32'h1000_0000, 32'h1000_0000));
    drain();

    // A threshold above the compression point puts the pole at luma 2L - C.
    configure(32'h8010_0000, 32'h0000_0000);
    push_pixel(rgb(32'h0020_0000, 32'h0020_0000, 32'h0020_0000));
    push_pixel(rgb(32'h001F_FFFF, 32'h001F_FFFF, 32'h001F_FFFF));
    push_pixel(rgb(32'h0020_0001, 32'h0020_0001, 32'h0020_0001));
    push_pixel(rgb(32'h7FFF_FFFF, 32'h0020_0000, 32'h0000_0000));
    push_pixel(rgb(32'h0020_0000, 32'h0020_0000, 32'h7FFF_FFFF));
    drain();

    for (int p = 0; p < 12; p++) begin
      calm = (p % 4 == 3);
      case (p)
        0: configure(32'h0000_0000, 32'h0000_0000);
        1: configure(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        2: configure(32'h0000_0000, 32'h7FFF_FFFF);
        3: configure(32'h7FFF_FFFF, 32'h0000_0000);
        default: begin
          thr_word  = ($urandom_range(0, 3) == 0) ? $urandom :
                      (($urandom & 32'h8000_0000) | $urandom_range(0, 32'h0400_0000));
          knee_word = ($urandom_range(0, 3) == 0) ? $urandom :
                      (($urandom & 32'h8000_0000) | $urandom_range(0, 32'h1000_0000));
          configure(thr_word, knee_word);
        end
      endcase
      repeat (94) push_pixel(random_pixel());
      drain();
    end

    // Give the pipeline time to show any result that was never asked for.
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
